/* design/rlpwm_pkg.sv */
// Shared types, codes and constants of the RGB LED PWM block.
`timescale 1ns / 1ps
package rlpwm_pkg;

  // Defaults of the top-level parameters
  localparam int PWM_MAX_DEF       = 65535;
  localparam int BLINK_TPM_DEF     = 2;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Duty scaling: duty = floor((v * g * PWM_MAX + ROUND_C) / DIV_C)
  localparam logic [31:0] ROUND_C = 32'd32512;
  localparam logic [17:0] DIV_C   = 18'd65025;
  localparam logic [17:0] DIV2_C  = 18'd130050;
  // floor(2^32 / DIV_C); estimate quotient falls short by at most two
  localparam logic [16:0] RECIP_C = 17'd66051;

  // Largest on_time_ms + off_time_ms
  localparam int SUM_MAX = 131070;

  localparam logic [7:0]  GAIN_RST = 8'd255;
  localparam logic [15:0] TIME_RST = 16'd500;

  typedef enum logic [1:0] {
    CMD_SET_COLOUR = 2'd0,
    CMD_PWM_TICK   = 2'd1,
    CMD_BLINK_TICK = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_GAIN   = 3'd0,
    REG_GREEN_GAIN = 3'd1,
    REG_BLUE_GAIN  = 3'd2,
    REG_BLINK_ON   = 3'd3,
    REG_ON_TIME    = 3'd4,
    REG_OFF_TIME   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_SCALE,
    S_RECIP,
    S_REM,
    S_FIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
  } in_item_t;

  typedef struct packed {
    logic        red_pin;
    logic        green_pin;
    logic        blue_pin;
    logic        lit_phase;
    logic [15:0] red_compare;
    logic [15:0] green_compare;
    logic [15:0] blue_compare;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic commit_duty;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_colour;
  } ctl_sts_t;

endpackage

/* design/rlpwm_chan_if.sv */
// Valid/ready channel interface carrying one item per handshake.
`timescale 1ns / 1ps
interface rlpwm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rlpwm_ctrl.sv */
// Controller state machine: item handshakes and sequencing of the duty scaler.
`timescale 1ns / 1ps
module rlpwm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rlpwm_pkg::ctl_sts_t sts,
  output rlpwm_pkg::ctl_cmd_t cmd
);
  import rlpwm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.is_colour ? S_GAIN : S_OUT;
        end
      end
      S_GAIN:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_REM;
      S_REM:   state_nxt = S_FIX;
      S_FIX: begin
        cmd.commit_duty = 1'b1;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/rlpwm_dp.sv */
// Datapath: configuration, PWM and blink counters, duty scaler, result register.
`timescale 1ns / 1ps
module rlpwm_dp #(
  parameter int PWM_MAX            = rlpwm_pkg::PWM_MAX_DEF,
  parameter int BLINK_TICKS_PER_MS = rlpwm_pkg::BLINK_TPM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rlpwm_pkg::ctl_cmd_t                cmd,
  output rlpwm_pkg::ctl_sts_t                sts,
  input  rlpwm_pkg::in_item_t                in_item,
  output rlpwm_pkg::out_item_t               out_item,
  input  logic                               cfg_we,
  input  logic [rlpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlpwm_pkg::CFG_W-1:0]        cfg_data
);
  import rlpwm_pkg::*;

  localparam int SPAN_W = $clog2(BLINK_TICKS_PER_MS * SUM_MAX + 1);
  localparam logic [15:0]       PWM_C = 16'(PWM_MAX);
  localparam logic [SPAN_W-1:0] TPM_C = SPAN_W'(BLINK_TICKS_PER_MS);

  // Configuration
  logic [7:0]  gain_r [3];
  logic        blink_on_r;
  logic [15:0] on_r, off_r;

  // Counters and duties
  logic [15:0]       pwm_r, pwm_nxt;
  logic [15:0]       duty_r [3];
  logic [SPAN_W-1:0] blink_cnt_r, blink_cnt_nxt;
  logic              enabled_r, enabled_nxt;

  // Scaler stages, one lane per colour
  logic [7:0]  val_r  [3];
  logic [15:0] prod_r [3];
  logic [31:0] num_r  [3];
  logic [31:0] numd_r [3];
  logic [15:0] q0_r   [3];
  logic [15:0] q0d_r  [3];
  logic [17:0] rem_r  [3];
  logic [32:0] qest   [3];
  logic [31:0] rem_full [3];
  logic [15:0] duty_fix [3];
  logic [7:0]  in_val [3];

  out_item_t out_r;

  logic [SPAN_W-1:0] lit_span, cycle_span, blink_inc;
  logic              cfg_restart, new_blink_on;
  logic [15:0]       new_on;
  logic [2:0]        pin;

  assign in_val[0] = in_item.red_value;
  assign in_val[1] = in_item.green_value;
  assign in_val[2] = in_item.blue_value;

  assign sts.is_colour = (in_item.command == CMD_SET_COLOUR);

  assign lit_span   = TPM_C * SPAN_W'(on_r);
  assign cycle_span = TPM_C * SPAN_W'({1'b0, on_r} + {1'b0, off_r});
  assign blink_inc  = blink_cnt_r + 1'b1;

  // Values the blink restart sees after a configuration write
  assign new_blink_on = (cfg_index == REG_BLINK_ON) ? cfg_data[0] : blink_on_r;
  assign new_on       = (cfg_index == REG_ON_TIME)  ? cfg_data    : on_r;
  assign cfg_restart  = cfg_we && ((cfg_index == REG_BLINK_ON) ||
                                   (cfg_index == REG_ON_TIME) ||
                                   (cfg_index == REG_OFF_TIME));

  always_comb begin
    pwm_nxt       = pwm_r;
    blink_cnt_nxt = blink_cnt_r;
    enabled_nxt   = enabled_r;
    if (cmd.accept) begin
      priority case (in_item.command)
        CMD_PWM_TICK: begin
          pwm_nxt = (pwm_r >= PWM_C) ? '0 : pwm_r + 1'b1;
        end
        CMD_BLINK_TICK: begin
          if (blink_on_r) begin
            blink_cnt_nxt = (blink_inc >= cycle_span) ? '0 : blink_inc;
            enabled_nxt   = (blink_cnt_nxt < lit_span);
          end
        end
        default: ;
      endcase
    end
    if (cmd.commit_duty) begin
      blink_cnt_nxt = '0;
      enabled_nxt   = !blink_on_r || (on_r != '0);
    end
    if (cfg_restart) begin
      blink_cnt_nxt = '0;
      enabled_nxt   = !new_blink_on || (new_on != '0);
    end
  end

  // Reciprocal estimate, remainder and final correction per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qest[k]     = 33'(num_r[k][31:16]) * 33'(RECIP_C);
      rem_full[k] = numd_r[k] - 32'(q0_r[k]) * 32'(DIV_C);
      if (rem_r[k] >= DIV2_C) begin
        duty_fix[k] = q0d_r[k] + 16'd2;
      end else if (rem_r[k] >= DIV_C) begin
        duty_fix[k] = q0d_r[k] + 16'd1;
      end else begin
        duty_fix[k] = q0d_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        gain_r[k] <= GAIN_RST;
        duty_r[k] <= '0;
      end
      blink_on_r  <= 1'b0;
      on_r        <= TIME_RST;
      off_r       <= TIME_RST;
      pwm_r       <= '0;
      blink_cnt_r <= '0;
      enabled_r   <= 1'b1;
    end else begin
      pwm_r       <= pwm_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      enabled_r   <= enabled_nxt;
      if (cmd.commit_duty) begin
        for (int k = 0; k < 3; k++) begin
          duty_r[k] <= duty_fix[k];
        end
      end
      if (cfg_we) begin
        priority case (cfg_index)
          REG_RED_GAIN:   gain_r[0]  <= cfg_data[7:0];
          REG_GREEN_GAIN: gain_r[1]  <= cfg_data[7:0];
          REG_BLUE_GAIN:  gain_r[2]  <= cfg_data[7:0];
          REG_BLINK_ON:   blink_on_r <= cfg_data[0];
          REG_ON_TIME:    on_r       <= cfg_data;
          REG_OFF_TIME:   off_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Scaler pipeline runs freely; the controller picks the result at the right cycle
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.accept) begin
        val_r[k] <= in_val[k];
      end
      prod_r[k] <= 16'(val_r[k]) * 16'(gain_r[k]);
      num_r[k]  <= 32'(prod_r[k]) * 32'(PWM_C) + ROUND_C;
      q0_r[k]   <= qest[k][31:16];
      numd_r[k] <= num_r[k];
      rem_r[k]  <= rem_full[k][17:0];
      q0d_r[k]  <= q0_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pin[k] = enabled_r && (pwm_r < duty_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.red_pin       <= pin[0];
      out_r.green_pin     <= pin[1];
      out_r.blue_pin      <= pin[2];
      out_r.lit_phase     <= enabled_r;
      out_r.red_compare   <= duty_r[0];
      out_r.green_compare <= duty_r[1];
      out_r.blue_compare  <= duty_r[2];
    end
  end

  assign out_item = out_r;

endmodule

/* design/rgb_led_pwm_with_blink.sv */
// Top level of the three-channel LED PWM generator with gain and blink gating.
// A tick item (PWM or blink) is accepted, then its result is loaded.
// A set-colour item passes through the five register stages of the duty
// scaler (gain multiply, PWM scale, reciprocal estimate, remainder, correction).
// Results sit in an output register; the next item is taken while one waits.
// Synchronous active-low reset: gains 255, times 500 ms, steady, duties zero.
`timescale 1ns / 1ps
module rgb_led_pwm_with_blink #(
  parameter int PWM_MAX            = rlpwm_pkg::PWM_MAX_DEF,
  parameter int BLINK_TICKS_PER_MS = rlpwm_pkg::BLINK_TPM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rlpwm_chan_if.sink                      in_ch,
  rlpwm_chan_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [rlpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlpwm_pkg::CFG_W-1:0]     cfg_data
);
  import rlpwm_pkg::*;

  ctl_cmd_t  cmd;
  ctl_sts_t  sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item     = in_ch.data;
  assign out_ch.data = out_item;

  rlpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlpwm_dp #(
    .PWM_MAX            (PWM_MAX),
    .BLINK_TICKS_PER_MS (BLINK_TICKS_PER_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
